// ----- hw/rtl/psp_pkg.sv -----
// psp_pkg: shared types and constants for the PDU signal pack/unpack block
// used by psp_sig_check and pdu_signal_pack_unpack; no dependencies

package psp_pkg;

    // buffer geometry
    localparam int PDU_BYTES = 64;
    localparam int BUF_BITS  = PDU_BYTES * 8;
    localparam int SH_W      = $clog2(BUF_BITS) + 1;

    // field widths fixed by the interface
    localparam int START_W  = 9;
    localparam int SIZE_W   = 7;
    localparam int LEN_W    = 7;
    localparam int VALUE_W  = 64;
    localparam int LAST_W   = 10;

    // reset value of the pdu length register
    localparam logic [LEN_W-1:0] PDU_LEN_RESET = LEN_W'(8);

    // operation codes
    typedef enum logic [1:0] {
        KIND_RX_WRITE = 2'd0,
        KIND_EXTRACT  = 2'd1,
        KIND_INSERT   = 2'd2,
        KIND_TX_READ  = 2'd3
    } kind_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SIZE = 2'd1,
        ST_TOO_LONG = 2'd2
    } status_t;

    // signal check result handed to the datapath
    typedef struct packed {
        status_t         status;
        logic [SH_W-1:0] shift;
    } sig_info_t;

endpackage

// ----- hw/rtl/psp_sig_check.sv -----
// psp_sig_check: validates a signal description and computes its buffer shift
// depends on psp_pkg

module psp_sig_check
    import psp_pkg::*;
(
    input  logic [START_W-1:0] sig_start,
    input  logic [SIZE_W-1:0]  sig_size,
    input  logic               big_endian,
    input  logic [LEN_W-1:0]   pdu_length,
    output sig_info_t          info
);

    logic [LAST_W-1:0]  first_pos;
    logic [LAST_W-1:0]  last_pos;
    logic [LAST_W-4:0]  hi_byte;
    logic [LEN_W-1:0]   len_eff;
    logic               size_bad;

    // motorola start bit maps to a msb-first linear position
    assign first_pos = big_endian
        ? LAST_W'({sig_start[START_W-1:3], ~sig_start[2:0]})
        : LAST_W'(sig_start);

    // last linear position touched by the signal
    assign last_pos = first_pos + LAST_W'(sig_size) - LAST_W'(1);
    assign hi_byte  = last_pos[LAST_W-1:3];

    // length saturated to the buffer size
    assign len_eff = (32'(pdu_length) > 32'(PDU_BYTES)) ? LEN_W'(PDU_BYTES) : pdu_length;

    assign size_bad = (sig_size == '0) || (sig_size > SIZE_W'(VALUE_W));

    // status and shift; big endian shifts over the byte-reversed buffer
    always_comb
    begin
        if (size_bad)
        begin
            info.status = ST_BAD_SIZE;
        end
        else if (32'(hi_byte) >= 32'(len_eff))
        begin
            info.status = ST_TOO_LONG;
        end
        else
        begin
            info.status = ST_OK;
        end

        if (big_endian)
        begin
            info.shift = SH_W'(BUF_BITS - 1) - SH_W'(last_pos);
        end
        else
        begin
            info.shift = SH_W'(sig_start);
        end
    end

endmodule

// ----- hw/rtl/pdu_signal_pack_unpack.sv -----
// pdu_signal_pack_unpack: top level with rx/tx pdu buffers and signal datapath
// depends on psp_pkg and psp_sig_check

// One transaction is accepted on every clock edge where start is high; busy is
// always low. A transaction is captured in an input register at the start edge,
// processed in the following cycle, and its result (kinds 1, 2 and 3) is registered
// in the result register and shown with done high for exactly one cycle.
// A receive-byte write (kind 0) gives no done pulse. The receiver cannot stall:
// results must be taken the cycle they are shown. Throughput is one transaction
// per clock, set by the combinational shift and mask across the 512-bit buffers.
// Successive transactions see the buffer updates of earlier ones. Users must write
// pdu_length via cfg_we/cfg_wdata only while no transaction is in flight (unenforced).

module pdu_signal_pack_unpack
    import psp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          kind,
    input  logic [5:0]          byte_index,
    input  logic [7:0]          byte_value,
    input  logic [START_W-1:0]  sig_start,
    input  logic [SIZE_W-1:0]   sig_size,
    input  logic                big_endian,
    input  logic [VALUE_W-1:0]  signal_value,
    input  logic                start_new,
    input  logic                cfg_we,
    input  logic [LEN_W-1:0]    cfg_wdata,
    output logic                done,
    output logic [VALUE_W-1:0]  result_value,
    output logic [1:0]          status
);

    // swap byte order of a whole buffer
    function automatic logic [BUF_BITS-1:0] byte_reverse(input logic [BUF_BITS-1:0] v);
        logic [BUF_BITS-1:0] r;
        for (int i = 0; i < PDU_BYTES; i++)
        begin
            r[i*8 +: 8] = v[(PDU_BYTES-1-i)*8 +: 8];
        end
        return r;
    endfunction

    // input register
    logic                item_vld_reg;
    kind_t               kind_reg;
    logic [5:0]          byte_index_reg;
    logic [7:0]          byte_value_reg;
    logic [START_W-1:0]  sig_start_reg;
    logic [SIZE_W-1:0]   sig_size_reg;
    logic                big_endian_reg;
    logic [VALUE_W-1:0]  signal_value_reg;
    logic                start_new_reg;

    // state
    logic [LEN_W-1:0]    pdu_length_reg;
    logic [BUF_BITS-1:0] rx_reg;
    logic [BUF_BITS-1:0] rx_next;
    logic [BUF_BITS-1:0] tx_reg;
    logic [BUF_BITS-1:0] tx_next;

    // result register
    logic                done_reg;
    logic                done_next;
    logic [VALUE_W-1:0]  result_value_reg;
    logic [VALUE_W-1:0]  result_value_next;
    status_t             status_reg;
    status_t             status_next;

    // datapath
    sig_info_t           info;
    logic [VALUE_W-1:0]  size_mask;
    logic [BUF_BITS-1:0] rx_view;
    logic [BUF_BITS-1:0] rx_shifted;
    logic [BUF_BITS-1:0] ins_view;
    logic [BUF_BITS-1:0] ins_buf;
    logic                byte_in_range;

    assign busy         = 1'b0;
    assign done         = done_reg;
    assign result_value = result_value_reg;
    assign status       = status_reg;

    psp_sig_check u_sig_check (
        .sig_start  (sig_start_reg),
        .sig_size   (sig_size_reg),
        .big_endian (big_endian_reg),
        .pdu_length (pdu_length_reg),
        .info       (info)
    );

    // value mask for 1..64 bit signals
    assign size_mask = {VALUE_W{1'b1}} >> (SIZE_W'(VALUE_W) - sig_size_reg);

    // extraction: shift the (byte-reversed for motorola) rx buffer down
    assign rx_view    = big_endian_reg ? byte_reverse(rx_reg) : rx_reg;
    assign rx_shifted = rx_view >> info.shift;

    // insertion: shift the masked value up, undo the byte reversal
    assign ins_view = BUF_BITS'(signal_value_reg & size_mask) << info.shift;
    assign ins_buf  = big_endian_reg ? byte_reverse(ins_view) : ins_view;

    assign byte_in_range = 32'(byte_index_reg) < 32'(PDU_BYTES);

    // operation decode
    always_comb
    begin
        rx_next           = rx_reg;
        tx_next           = tx_reg;
        done_next         = 1'b0;
        result_value_next = '0;
        status_next       = ST_OK;

        if (item_vld_reg)
        begin
            unique case (kind_reg)
                KIND_RX_WRITE:
                begin
                    if (byte_in_range)
                    begin
                        rx_next[{byte_index_reg, 3'b000} +: 8] = byte_value_reg;
                    end
                end
                KIND_EXTRACT:
                begin
                    done_next   = 1'b1;
                    status_next = info.status;
                    if (info.status == ST_OK)
                    begin
                        result_value_next = rx_shifted[VALUE_W-1:0] & size_mask;
                    end
                end
                KIND_INSERT:
                begin
                    done_next   = 1'b1;
                    status_next = info.status;
                    if (info.status == ST_OK)
                    begin
                        tx_next = (start_new_reg ? '0 : tx_reg) | ins_buf;
                    end
                end
                KIND_TX_READ:
                begin
                    done_next = 1'b1;
                    if (byte_in_range)
                    begin
                        result_value_next = VALUE_W'(tx_reg[{byte_index_reg, 3'b000} +: 8]);
                    end
                end
                default:
                begin
                    done_next = 1'b0;
                end
            endcase
        end
    end

    // control and buffer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg   <= 1'b0;
            done_reg       <= 1'b0;
            status_reg     <= ST_OK;
            pdu_length_reg <= PDU_LEN_RESET;
            rx_reg         <= '0;
            tx_reg         <= '0;
        end
        else
        begin
            item_vld_reg <= start && !busy;
            done_reg     <= done_next;
            status_reg   <= status_next;
            rx_reg       <= rx_next;
            tx_reg       <= tx_next;
            if (cfg_we)
            begin
                pdu_length_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            kind_reg         <= kind_t'(kind);
            byte_index_reg   <= byte_index;
            byte_value_reg   <= byte_value;
            sig_start_reg    <= sig_start;
            sig_size_reg     <= sig_size;
            big_endian_reg   <= big_endian;
            signal_value_reg <= signal_value;
            start_new_reg    <= start_new;
        end
        result_value_reg <= result_value_next;
    end

    // a result only follows a captured transaction
    a_done_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(item_vld_reg))
        else $error("done without a captured transaction");

    // rejected signals return a zero value
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (result_value == '0))
        else $error("rejected signal returned a nonzero value");

    // rx buffer changes only through a receive-byte write
    a_rx_write_only: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(rx_reg) |-> $past(item_vld_reg && kind_reg == KIND_RX_WRITE))
        else $error("rx buffer changed without a byte write");

    // tx buffer changes only through an accepted insert
    a_tx_insert_only: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(tx_reg) |->
            $past(item_vld_reg && kind_reg == KIND_INSERT && info.status == ST_OK))
        else $error("tx buffer changed without a valid insert");

    // tx byte read always reports ok
    a_tx_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (item_vld_reg && kind_reg == KIND_TX_READ) |=> (done && status == ST_OK))
        else $error("tx byte read did not return ok");

endmodule

// ----- verif/pdu_signal_pack_unpack_test.sv -----
// pdu_signal_pack_unpack_test: self-checking bench for the pdu signal pack/unpack block
// drives directed and random transactions through start/busy, checks done results
// against a buffer-level predictor; depends on psp_pkg and pdu_signal_pack_unpack
`timescale 1ns / 100ps

module pdu_signal_pack_unpack_test
    import psp_pkg::*;
();

    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_OPS    = 250;
    localparam int NUM_PHASES   = 8;
    localparam int SETTLE_TICKS = 4;
    localparam int MAX_GAP      = 17;

    // one transaction as presented on the input ports
    typedef struct {
        kind_t                kind;
        logic [5:0]           idx;
        logic [7:0]           bval;
        logic [START_W-1:0]   sbit;
        logic [SIZE_W-1:0]    size;
        logic                 be;
        logic [VALUE_W-1:0]   sval;
        logic                 fresh;
    } sig_op_t;

    // one expected done pulse
    typedef struct {
        logic [VALUE_W-1:0] value;
        status_t            st;
    } sig_result_t;

    // directed row, with a hand-typed result where it is obvious
    typedef struct {
        sig_op_t            op;
        bit                 typed;
        logic [VALUE_W-1:0] tv;
        status_t            tst;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          kind = '0;
    logic [5:0]          byte_index = '0;
    logic [7:0]          byte_value = '0;
    logic [START_W-1:0]  sig_start = '0;
    logic [SIZE_W-1:0]   sig_size = '0;
    logic                big_endian = 1'b0;
    logic [VALUE_W-1:0]  signal_value = '0;
    logic                start_new = 1'b0;
    logic                cfg_we = 1'b0;
    logic [LEN_W-1:0]    cfg_wdata = '0;
    logic                done;
    logic [VALUE_W-1:0]  result_value;
    logic [1:0]          status;

    // predictor state
    logic [7:0]          rx_buf [PDU_BYTES];
    logic [7:0]          tx_buf [PDU_BYTES];
    logic [LEN_W-1:0]    pdu_len;

    sig_result_t         pending_results[$];
    dir_row_t            directed_rows[$];
    int                  err_count = 0;
    int                  cycles = 0;
    int                  burst_left = 0;

    pdu_signal_pack_unpack u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .byte_index   (byte_index),
        .byte_value   (byte_value),
        .sig_start    (sig_start),
        .sig_size     (sig_size),
        .big_endian   (big_endian),
        .signal_value (signal_value),
        .start_new    (start_new),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .result_value (result_value),
        .status       (status)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        err_count++;
    endtask

    // result checker: done cannot be held off, so every pulse is taken
    always @(posedge clk)
    begin
        sig_result_t exp_res;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", result_value, '0);
            else
            begin
                exp_res = pending_results.pop_front();
                if (result_value !== exp_res.value)
                    report_mismatch("result_value", result_value, exp_res.value);
                if (status !== exp_res.st)
                    report_mismatch("status", {62'b0, status}, {62'b0, exp_res.st});
            end
        end
    end

    // buffer-level predictor: applies one transaction and returns its result
    function automatic void predict_sig_op(input sig_op_t op, output bit has_res,
                                           output logic [VALUE_W-1:0] val,
                                           output status_t st);
        int eff_len;
        int net0;
        int hi;
        int bpos;
        int byte_n;
        int bit_n;
        logic [VALUE_W-1:0] masked;
        has_res = 1'b0;
        val     = '0;
        st      = ST_OK;
        case (op.kind)
            KIND_RX_WRITE:
                rx_buf[op.idx] = op.bval;
            KIND_TX_READ:
            begin
                has_res = 1'b1;
                val     = {56'b0, tx_buf[op.idx]};
            end
            default:
            begin
                has_res = 1'b1;
                eff_len = (int'(pdu_len) > PDU_BYTES) ? PDU_BYTES : int'(pdu_len);
                // motorola start bit names the msb; map it to a linear position
                net0 = op.be ? 8 * (int'(op.sbit) / 8) + 7 - int'(op.sbit) % 8
                             : int'(op.sbit);
                if (op.size == 0 || op.size > 64)
                    st = ST_BAD_SIZE;
                else
                begin
                    hi = (net0 + int'(op.size) - 1) / 8;
                    if (hi >= eff_len)
                        st = ST_TOO_LONG;
                end
                if (st == ST_OK)
                begin
                    masked = (op.size == 64) ? op.sval
                                             : op.sval & ((64'd1 << op.size) - 64'd1);
                    if (op.kind == KIND_INSERT && op.fresh)
                        foreach (tx_buf[i])
                            tx_buf[i] = '0;
                    for (int k = 0; k < int'(op.size); k++)
                    begin
                        bpos   = op.be ? net0 + int'(op.size) - 1 - k : net0 + k;
                        byte_n = bpos / 8;
                        bit_n  = op.be ? 7 - bpos % 8 : bpos % 8;
                        if (byte_n < PDU_BYTES)
                        begin
                            if (op.kind == KIND_EXTRACT)
                                val[k] = rx_buf[byte_n][bit_n];
                            else if (masked[k])
                                tx_buf[byte_n][bit_n] = 1'b1;
                        end
                    end
                    if (op.kind == KIND_INSERT)
                        val = '0;
                end
            end
        endcase
    endfunction

    // drive one transaction after a random gap, predict it at the accept edge
    task automatic send_op(input sig_op_t op, input bit typed,
                           input logic [VALUE_W-1:0] tv, input status_t tst);
        int gap;
        bit has_res;
        logic [VALUE_W-1:0] pv;
        status_t ps;
        sig_result_t exp_res;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 15) == 0)
                burst_left = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        kind         <= op.kind;
        byte_index   <= op.idx;
        byte_value   <= op.bval;
        sig_start    <= op.sbit;
        sig_size     <= op.size;
        big_endian   <= op.be;
        signal_value <= op.sval;
        start_new    <= op.fresh;
        do @(posedge clk); while (busy);
        predict_sig_op(op, has_res, pv, ps);
        if (has_res)
        begin
            exp_res.value = typed ? tv : pv;
            exp_res.st    = typed ? tst : ps;
            pending_results = {pending_results, exp_res};
        end
    endtask

    // stop issuing and let every result and any trailing rx write finish
    task automatic settle();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_pdu_length(input logic [LEN_W-1:0] len);
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pdu_len    = len;
    endtask

    function automatic sig_op_t mk_op(input kind_t k, input int idx,
                                      input logic [7:0] bval, input int sbit,
                                      input int size, input int be,
                                      input logic [VALUE_W-1:0] sval, input int fresh);
        sig_op_t op;
        op.kind  = k;
        op.idx   = 6'(idx);
        op.bval  = bval;
        op.sbit  = START_W'(sbit);
        op.size  = SIZE_W'(size);
        op.be    = 1'(be);
        op.sval  = sval;
        op.fresh = 1'(fresh);
        return op;
    endfunction

    function automatic void add_row(input sig_op_t op, input bit typed = 1'b0,
                                    input logic [VALUE_W-1:0] tv = '0,
                                    input status_t tst = ST_OK);
        dir_row_t row;
        row.op    = op;
        row.typed = typed;
        row.tv    = tv;
        row.tst   = tst;
        directed_rows = {directed_rows, row};
    endfunction

    // random transaction: mostly signals that fit the current length, some noise
    function automatic sig_op_t random_op();
        sig_op_t op;
        int eff_len;
        int max_size;
        int net;
        int pick;
        eff_len = (int'(pdu_len) > PDU_BYTES) ? PDU_BYTES : int'(pdu_len);
        op.idx   = 6'($urandom());
        op.bval  = 8'($urandom());
        op.sbit  = START_W'($urandom());
        op.size  = SIZE_W'($urandom());
        op.be    = 1'($urandom());
        op.sval  = {$urandom(), $urandom()};
        op.fresh = ($urandom_range(0, 7) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 30)
            op.kind = KIND_RX_WRITE;
        else if (pick < 55)
            op.kind = KIND_EXTRACT;
        else if (pick < 80)
            op.kind = KIND_INSERT;
        else
            op.kind = KIND_TX_READ;
        // keep byte accesses mostly inside the live part of the pdu
        if (eff_len > 0 && $urandom_range(0, 3) != 0)
            op.idx = 6'($urandom_range(0, eff_len - 1));
        // well-formed signal placement
        if ((op.kind == KIND_EXTRACT || op.kind == KIND_INSERT) && eff_len > 0
            && $urandom_range(0, 99) >= 20)
        begin
            max_size = (8 * eff_len < 64) ? 8 * eff_len : 64;
            op.size  = SIZE_W'(($urandom_range(0, 3) == 0) ? max_size
                                                           : $urandom_range(1, max_size));
            net = $urandom_range(0, 8 * eff_len - int'(op.size));
            op.sbit = START_W'(op.be ? 8 * (net / 8) + 7 - net % 8 : net);
        end
        return op;
    endfunction

    initial
    begin
        logic [LEN_W-1:0] len;
        foreach (rx_buf[i])
        begin
            rx_buf[i] = '0;
            tx_buf[i] = '0;
        end
        pdu_len = PDU_LEN_RESET;

        // directed table; reset length is 8 bytes
        add_row(mk_op(KIND_TX_READ, 0, 8'h00, 0, 0, 0, '0, 0), 1'b1, '0, ST_OK);
        add_row(mk_op(KIND_EXTRACT, 0, 8'h00, 0, 8, 0, '0, 0), 1'b1, '0, ST_OK);
        add_row(mk_op(KIND_EXTRACT, 0, 8'h00, 0, 0, 0, '0, 0), 1'b1, '0, ST_BAD_SIZE);
        add_row(mk_op(KIND_EXTRACT, 0, 8'h00, 0, 65, 1, '0, 0), 1'b1, '0, ST_BAD_SIZE);
        add_row(mk_op(KIND_INSERT, 0, 8'h00, 511, 127, 1, '1, 1), 1'b1, '0, ST_BAD_SIZE);
        add_row(mk_op(KIND_INSERT, 0, 8'h00, 0, 0, 0, '1, 0), 1'b1, '0, ST_BAD_SIZE);
        add_row(mk_op(KIND_EXTRACT, 0, 8'h00, 1, 64, 0, '0, 0), 1'b1, '0, ST_TOO_LONG);
        add_row(mk_op(KIND_EXTRACT, 0, 8'h00, 511, 1, 1, '0, 0), 1'b1, '0, ST_TOO_LONG);
        add_row(mk_op(KIND_RX_WRITE, 0, 8'hFF, 0, 0, 0, '0, 0));
        add_row(mk_op(KIND_RX_WRITE, 7, 8'h81, 0, 0, 0, '0, 0));
        add_row(mk_op(KIND_RX_WRITE, 63, 8'hA5, 0, 0, 0, '0, 0));
        add_row(mk_op(KIND_RX_WRITE, 3, 8'h5A, 0, 0, 0, '0, 0));
        add_row(mk_op(KIND_EXTRACT, 0, 8'h00, 0, 64, 0, '0, 0));
        add_row(mk_op(KIND_EXTRACT, 0, 8'h00, 7, 64, 1, '0, 0));
        add_row(mk_op(KIND_EXTRACT, 0, 8'h00, 56, 1, 1, '0, 0));
        add_row(mk_op(KIND_EXTRACT, 0, 8'h00, 29, 11, 1, '0, 0));
        add_row(mk_op(KIND_INSERT, 0, 8'h00, 0, 64, 0, '1, 1), 1'b1, '0, ST_OK);
        add_row(mk_op(KIND_TX_READ, 7, 8'h00, 0, 0, 0, '0, 0), 1'b1, 64'hFF, ST_OK);
        add_row(mk_op(KIND_INSERT, 0, 8'h00, 7, 12, 1, 64'hFFFF_0ABC, 1), 1'b1, '0, ST_OK);
        add_row(mk_op(KIND_TX_READ, 0, 8'h00, 0, 0, 0, '0, 0));
        add_row(mk_op(KIND_TX_READ, 1, 8'h00, 0, 0, 0, '0, 0));
        // rejected insert must not clear the buffer
        add_row(mk_op(KIND_INSERT, 0, 8'h00, 60, 8, 0, '1, 1), 1'b1, '0, ST_TOO_LONG);
        add_row(mk_op(KIND_TX_READ, 0, 8'h00, 0, 0, 0, '0, 0));
        add_row(mk_op(KIND_INSERT, 0, 8'h00, 8, 4, 0, '1, 0), 1'b1, '0, ST_OK);
        add_row(mk_op(KIND_TX_READ, 1, 8'h00, 0, 0, 0, '0, 0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_op(directed_rows[i].op, directed_rows[i].typed,
                    directed_rows[i].tv, directed_rows[i].tst);

        // random phases over several pdu lengths, extremes first
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: len = LEN_W'(64);
                1: len = LEN_W'(1);
                2: len = LEN_W'(0);
                3: len = LEN_W'(127);
                4: len = LEN_W'(8);
                default: len = LEN_W'($urandom_range(1, 64));
            endcase
            settle();
            write_pdu_length(len);
            repeat (PHASE_OPS)
                send_op(random_op(), 1'b0, '0, ST_OK);
        end

        settle();
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
